/* rtl/zsc_pkg.sv */
`default_nettype none
package zsc_pkg;

  localparam int MAX_ZONES_DEFAULT = 1024;
  localparam int ZONE_W = 16;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BELOW = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_AREA = 1'b1;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic              cmd;
    logic [1:0]        status;
    logic [ZONE_W-1:0] zone;
    logic [31:0]       value;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count;
    logic [63:0] total;
    logic [63:0] average;
    logic [63:0] zone_vol;
    logic [63:0] grand_vol;
  } result_t;

  function automatic logic [63:0] sign_sat(input logic neg, input logic [63:0] mag,
                                           input logic ovf);
    logic [63:0] r;
    if (neg) begin
      r = (ovf || mag[63]) ? NEG_MAX : (64'd0 - mag);
    end else begin
      r = (ovf || mag[63]) ? POS_MAX : mag;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? NEG_MAX : POS_MAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] area_volume(input logic neg, input logic [63:0] lo,
                                              input logic [63:0] hi);
    logic [64:0] s;
    logic        ovf;
    s = {1'b0, hi[31:0], 32'd0} + {1'b0, lo};
    ovf = (hi[63:32] != 32'd0) || s[64];
    return sign_sat(neg, s[63:0], ovf);
  endfunction

endpackage
`default_nettype wire

/* rtl/zsc_front.sv */
`default_nettype none
module zsc_front #(
  parameter int MAX_ZONES = zsc_pkg::MAX_ZONES_DEFAULT
) (
  input  wire logic           command,
  input  wire logic [31:0]    zone_label,
  input  wire logic [31:0]    data_value,
  input  wire logic [9:0]     category_limit,
  output zsc_pkg::item_t      item
);

  logic below;
  logic range_err;

  always_comb begin
    below = zone_label[31] || (zone_label == 32'd0);
    range_err = (zone_label > {22'd0, category_limit}) ||
                (zone_label >= 32'(MAX_ZONES));
    item.cmd = command;
    item.value = data_value;
    item.zone = '0;
    if (below) begin
      item.status = zsc_pkg::ST_BELOW;
    end else if (range_err) begin
      item.status = zsc_pkg::ST_RANGE;
    end else begin
      item.status = zsc_pkg::ST_OK;
      item.zone = zone_label[zsc_pkg::ZONE_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/zsc_queue.sv */
`default_nettype none
module zsc_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  zsc_pkg::item_t din,
  output logic           full,
  input  wire logic      pop,
  output logic           valid,
  output zsc_pkg::item_t dout
);

  zsc_pkg::item_t ent [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  assign full = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign dout = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/zsc_back.sv */
`default_nettype none
module zsc_back #(
  parameter int MAX_ZONES = zsc_pkg::MAX_ZONES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] cell_area,
  input  wire logic        q_valid,
  input  zsc_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             cleared,
  output logic             out_valid,
  input  wire logic        out_taken,
  output zsc_pkg::result_t result
);

  localparam int ZW = $clog2(MAX_ZONES);
  localparam int DIV_STEPS = 72;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MUL0 = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_MULF = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;

  logic [95:0]    mem [MAX_ZONES];
  logic [95:0]    rd_data;
  logic           mem_we;
  logic [ZW-1:0]  mem_wa;
  logic [95:0]    mem_wd;

  logic [2:0]     state;
  logic [ZW-1:0]  clr_addr;
  zsc_pkg::item_t cur;
  logic [63:0]    grand_sum;
  logic           mul_sel;
  logic [63:0]    plo;
  logic [63:0]    phi;
  logic [31:0]    div_rem;
  logic [71:0]    div_dvd;
  logic [71:0]    div_quo;
  logic [6:0]     div_cnt;

  logic [63:0]    rd_sum;
  logic [31:0]    rd_cnt;
  logic [63:0]    gmag;
  logic [63:0]    zmag;
  logic [63:0]    mag_sel;
  logic           neg_sel;
  logic [31:0]    mul_a;
  logic [63:0]    mul_p;
  logic [63:0]    vol;
  logic [63:0]    value64;
  logic [32:0]    rem_sh;
  logic           rem_ge;
  logic [31:0]    rem_next;
  logic [71:0]    quo_next;

  assign rd_sum = rd_data[95:32];
  assign rd_cnt = rd_data[31:0];
  assign cleared = (state != S_CLR);
  assign q_pop = (state == S_IDLE) && q_valid && !out_valid;
  assign value64 = {{32{cur.value[31]}}, cur.value};

  always_comb begin
    gmag = grand_sum[63] ? (64'd0 - grand_sum) : grand_sum;
    zmag = rd_sum[63] ? (64'd0 - rd_sum) : rd_sum;
    mag_sel = mul_sel ? zmag : gmag;
    neg_sel = mul_sel ? rd_sum[63] : grand_sum[63];
    mul_a = (state == S_MUL1) ? mag_sel[63:32] : mag_sel[31:0];
    mul_p = 64'(mul_a) * 64'(cell_area);
    vol = zsc_pkg::area_volume(neg_sel, plo, phi);
    rem_sh = {div_rem, div_dvd[71]};
    rem_ge = (rem_sh >= {1'b0, rd_cnt});
    rem_next = rem_ge ? 32'(rem_sh - {1'b0, rd_cnt}) : rem_sh[31:0];
    quo_next = {div_quo[70:0], rem_ge};
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = '0;
    if (state == S_CLR) begin
      mem_we = 1'b1;
    end else if (state == S_ACC) begin
      mem_we = 1'b1;
      mem_wa = cur.zone[ZW-1:0];
      mem_wd[95:32] = zsc_pkg::sat_add64(rd_sum, value64);
      mem_wd[31:0] = (rd_cnt == 32'hFFFF_FFFF) ? rd_cnt : rd_cnt + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_data <= mem[q_item.zone[ZW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      grand_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_taken) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + ZW'(1);
          if (clr_addr == ZW'(MAX_ZONES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_item;
            result <= {q_item.status, 288'd0};
            mul_sel <= 1'b0;
            if (q_item.cmd == zsc_pkg::CMD_ACCUM) begin
              if (q_item.status == zsc_pkg::ST_OK) begin
                state <= S_ACC;
              end else begin
                out_valid <= 1'b1;
              end
            end else begin
              state <= S_MUL0;
            end
          end
        end
        S_ACC: begin
          grand_sum <= zsc_pkg::sat_add64(grand_sum, value64);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_MUL0: begin
          plo <= mul_p;
          state <= S_MUL1;
        end
        S_MUL1: begin
          phi <= mul_p;
          state <= S_MULF;
        end
        S_MULF: begin
          if (!mul_sel) begin
            result.grand_vol <= vol;
            if (cur.status != zsc_pkg::ST_OK) begin
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else if (rd_cnt == 32'd0) begin
              result.status <= zsc_pkg::ST_EMPTY;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              mul_sel <= 1'b1;
              state <= S_MUL0;
            end
          end else begin
            result.zone_vol <= vol;
            result.count <= rd_cnt;
            result.total <= rd_sum;
            div_dvd <= {zmag, 8'd0};
            div_rem <= '0;
            div_quo <= '0;
            div_cnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem <= rem_next;
          div_quo <= quo_next;
          div_dvd <= {div_dvd[70:0], 1'b0};
          div_cnt <= div_cnt + 7'd1;
          if (div_cnt == 7'(DIV_STEPS - 1)) begin
            result.average <= zsc_pkg::sign_sat(rd_sum[63], quo_next[63:0],
                                                quo_next[71:63] != 9'd0);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/zonal_sum_count_statistics.sv */
`default_nettype none
// Channel   Direction  Signals                         Contents
// s_axis    in         s_tvalid s_tready s_tdata s_tuser  one command per transaction
// m_axis    out        m_tvalid m_tready m_tdata m_tuser  one result per transaction
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// An accumulate in the back end reads the zone entry, then updates and writes it back, then
// hands the result over; a rejected label skips the update.
// A query works out the grand volume and, when the zone holds cells, the zone volume and the
// average, with two 32x32 products for each volume and a 72-step restoring divider for the average.
// After reset the zone memory is cleared one entry a cycle, with s_tready low.
// A two-entry queue lets the input side keep accepting while the back end or m_axis stalls.
module zonal_sum_count_statistics #(
  parameter int MAX_ZONES = zsc_pkg::MAX_ZONES_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // zone_label, data_value
  input  wire logic         s_tuser,   // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [287:0]      m_tdata,   // cell_count, data_total, average_value,
                                       // zone_volume, grand_volume
  output logic [1:0]        m_tuser,   // status
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);

  logic [9:0]       category_limit;
  logic [31:0]      cell_area;
  zsc_pkg::item_t   front_item;
  zsc_pkg::item_t   q_item;
  zsc_pkg::result_t result;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             cleared;

  assign cfg_ready = 1'b1;
  assign s_tready = !q_full && cleared;

  always_ff @(posedge clk) begin
    if (rst) begin
      category_limit <= 10'd1023;
      cell_area <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == zsc_pkg::CFG_LIMIT) begin
        category_limit <= cfg_data[9:0];
      end else begin
        cell_area <= cfg_data;
      end
    end
  end

  zsc_front #(.MAX_ZONES(MAX_ZONES)) u_front (
    .command        (s_tuser),
    .zone_label     (s_tdata[31:0]),
    .data_value     (s_tdata[63:32]),
    .category_limit (category_limit),
    .item           (front_item)
  );

  zsc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (s_tvalid && s_tready),
    .din   (front_item),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_item)
  );

  zsc_back #(.MAX_ZONES(MAX_ZONES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cell_area (cell_area),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cleared   (cleared),
    .out_valid (m_tvalid),
    .out_taken (m_tready),
    .result    (result)
  );

  assign m_tuser = result.status;
  assign m_tdata = {result.grand_vol, result.zone_vol, result.average,
                    result.total, result.count};

endmodule
`default_nettype wire

/* test/tb_zonal_sum_count_statistics.sv */
`timescale 1ns / 1ps
module tb_zonal_sum_count_statistics;

  localparam int ZONES = 1024;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 120;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;
  logic         s_tuser = zsc_pkg::CMD_ACCUM;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [287:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = zsc_pkg::CFG_LIMIT;
  logic [31:0]  cfg_data = '0;

  zonal_sum_count_statistics dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the zone store and registers.
  logic [9:0]        label_limit;
  logic [31:0]       area_q16;
  longint            zone_total[ZONES];
  int unsigned       zone_cells[ZONES];
  longint            grand_total;

  zsc_pkg::result_t  pending_stats[$];
  int                mismatches = 0;
  int                cycles = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;

  function automatic longint sat_sum(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return zsc_pkg::POS_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return zsc_pkg::NEG_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] clamp_signed(input logic neg, input logic [95:0] mag);
    if (neg) begin
      return (mag >= 96'h8000_0000_0000_0000) ? zsc_pkg::NEG_MAX : 64'd0 - mag[63:0];
    end
    return (mag > 96'h7FFF_FFFF_FFFF_FFFF) ? zsc_pkg::POS_MAX : mag[63:0];
  endfunction

  function automatic logic [63:0] scale_by_area(input longint v);
    logic [63:0] mag;
    logic [95:0] prod;
    mag = (v < 0) ? 64'd0 - v : v;
    prod = {32'd0, mag} * {64'd0, area_q16};
    return clamp_signed(v < 0, prod);
  endfunction

  function automatic logic [63:0] mean_q8(input longint total, input int unsigned cnt);
    logic [63:0] mag;
    logic [95:0] q;
    mag = (total < 0) ? 64'd0 - total : total;
    q = {24'd0, mag, 8'd0} / {64'd0, cnt};
    return clamp_signed(total < 0, q);
  endfunction

  function automatic zsc_pkg::result_t zone_stats_update(input logic cmd,
                                                         input logic signed [31:0] label,
                                                         input logic signed [31:0] value);
    zsc_pkg::result_t r;
    int               z;
    r = '0;
    z = 0;
    if (label < 1) r.status = zsc_pkg::ST_BELOW;
    else if (label > $signed({22'd0, label_limit}) || label >= ZONES)
      r.status = zsc_pkg::ST_RANGE;
    else begin
      r.status = zsc_pkg::ST_OK;
      z = label;
    end
    if (cmd == zsc_pkg::CMD_ACCUM) begin
      if (r.status == zsc_pkg::ST_OK) begin
        if (zone_cells[z] != 32'hFFFF_FFFF) zone_cells[z]++;
        zone_total[z] = sat_sum(zone_total[z], longint'(value));
        grand_total = sat_sum(grand_total, longint'(value));
      end
      return r;
    end
    r.grand_vol = scale_by_area(grand_total);
    if (r.status == zsc_pkg::ST_OK) begin
      if (zone_cells[z] == 0) r.status = zsc_pkg::ST_EMPTY;
      else begin
        r.count = zone_cells[z];
        r.total = zone_total[z];
        r.average = mean_q8(zone_total[z], zone_cells[z]);
        r.zone_vol = scale_by_area(zone_total[z]);
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [31:0] label, input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {value, label};
    do @(posedge clk); while (!s_tready);
    pending_stats.push_back(zone_stats_update(cmd, label, value));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == zsc_pkg::CFG_LIMIT) label_limit = data[9:0];
    else area_q16 = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_label_classes();
    send_item(zsc_pkg::CMD_QUERY, 32'd1, 32'd0);
    send_item(zsc_pkg::CMD_ACCUM, 32'd0, 32'd5);
    send_item(zsc_pkg::CMD_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(zsc_pkg::CMD_ACCUM, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(zsc_pkg::CMD_ACCUM, 32'd1024, 32'd9);
    send_item(zsc_pkg::CMD_ACCUM, 32'd1023, 32'h7FFF_FFFF);
    send_item(zsc_pkg::CMD_ACCUM, 32'd1, 32'h8000_0000);
    send_item(zsc_pkg::CMD_ACCUM, 32'd1, 32'd3);
    send_item(zsc_pkg::CMD_QUERY, 32'd1023, 32'hFFFF_FFFF);
    send_item(zsc_pkg::CMD_QUERY, 32'd1, 32'd0);
    send_item(zsc_pkg::CMD_QUERY, 32'd0, 32'd0);
    send_item(zsc_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'd0);
    send_item(zsc_pkg::CMD_QUERY, 32'd2000, 32'd0);
  endtask

  task automatic test_volume_saturation();
    write_reg(zsc_pkg::CFG_AREA, 32'hFFFF_FFFF);
    repeat (3) send_item(zsc_pkg::CMD_ACCUM, 32'd5, 32'h7FFF_FFFF);
    send_item(zsc_pkg::CMD_QUERY, 32'd5, 32'd0);
    repeat (6) send_item(zsc_pkg::CMD_ACCUM, 32'd6, 32'h8000_0000);
    send_item(zsc_pkg::CMD_QUERY, 32'd6, 32'd0);
    write_reg(zsc_pkg::CFG_AREA, 32'd0);
    send_item(zsc_pkg::CMD_QUERY, 32'd5, 32'd0);
  endtask

  task automatic test_limit_extremes();
    write_reg(zsc_pkg::CFG_LIMIT, 32'd0);
    send_item(zsc_pkg::CMD_ACCUM, 32'd1, 32'd7);
    send_item(zsc_pkg::CMD_QUERY, 32'd1, 32'd0);
    write_reg(zsc_pkg::CFG_LIMIT, 32'd1);
    send_item(zsc_pkg::CMD_ACCUM, 32'd2, 32'd7);
    send_item(zsc_pkg::CMD_QUERY, 32'd1, 32'd0);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
    logic        cmd;
    logic [31:0] label;
    logic [31:0] value;
    int          pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) begin
      cmd = ($urandom_range(99) < 15) ? zsc_pkg::CMD_QUERY : zsc_pkg::CMD_ACCUM;
      pick = $urandom_range(99);
      if (pick < 60) label = $urandom_range(1, 24);
      else if (pick < 80) label = $urandom_range(0, 1100);
      else if (pick < 88) label = -$urandom_range(0, 8);
      else label = $urandom;
      pick = $urandom_range(99);
      if (pick < 10) value = 32'h7FFF_FFFF;
      else if (pick < 20) value = 32'h8000_0000;
      else if (pick < 50) value = $urandom_range(0, 500) - 250;
      else value = $urandom;
      send_item(cmd, label, value);
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h actual %h", name, want, got);
    end
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    zsc_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        want = pending_stats.pop_front();
        check_field("status", 64'(want.status), 64'(m_tuser));
        check_field("cell_count", 64'(want.count), 64'(m_tdata[31:0]));
        check_field("data_total", want.total, m_tdata[95:32]);
        check_field("average_value", want.average, m_tdata[159:96]);
        check_field("zone_volume", want.zone_vol, m_tdata[223:160]);
        check_field("grand_volume", want.grand_vol, m_tdata[287:224]);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_zonal_sum_count_statistics failed");
      $finish;
    end
  end

  initial begin
    label_limit = 10'd1023;
    area_q16 = 32'd65536;
    foreach (zone_total[k]) begin
      zone_total[k] = 0;
      zone_cells[k] = 0;
    end
    grand_total = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_label_classes();
    test_volume_saturation();
    test_limit_extremes();
    write_reg(zsc_pkg::CFG_LIMIT, 32'd1023);
    write_reg(zsc_pkg::CFG_AREA, 32'd65536);
    test_random_traffic(650, 26, 59);
    write_reg(zsc_pkg::CFG_LIMIT, $urandom_range(24, 1022));
    write_reg(zsc_pkg::CFG_AREA, $urandom);
    test_random_traffic(650, 59, 26);
    write_reg(zsc_pkg::CFG_LIMIT, 32'd1023);
    write_reg(zsc_pkg::CFG_AREA, 32'h0001_8000);
    test_random_traffic(650, 0, 0);
    wait_drained();

    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("tb_zonal_sum_count_statistics passed");
    end else begin
      $display("tb_zonal_sum_count_statistics failed");
    end
    $finish;
  end

endmodule
